>>> design/double_ended_queue_unit_defines.svh
// assertion macros for the double-ended queue unit
// used by double_ended_queue_unit.sv, which supplies clk and rst in scope
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/deq_pkg.sv
// shared types and codes for the double-ended queue unit
// no dependencies; imported by the interfaces and all modules
package deq_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SHOW       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic                     last;
  } result_t;

endpackage

>>> design/deq_in_if.sv
// request channel of the double-ended queue unit: operation and value
// depends on deq_pkg
interface deq_in_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink (input valid, operation, value, output ready);
endinterface

>>> design/deq_out_if.sv
// result channel of the double-ended queue unit: data, status, last
// depends on deq_pkg
interface deq_out_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [1:0]               status;
  logic                     last;

  modport source (output valid, data, status, last, input ready);
  modport sink (input valid, data, status, last, output ready);
endinterface

>>> design/deq_mem.sv
// entry store: one write port, one read port, registered read data
// depends on deq_pkg
module deq_mem import deq_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/deq_ctrl.sv
// sequencer of the double-ended queue: ring pointers, memory accesses, results
// depends on deq_pkg and deq_in_if
module deq_ctrl import deq_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int OW    = 6
) (
  input  logic              clk,
  input  logic              rst,
  deq_in_if.sink            req,
  output logic              res_valid,
  output result_t           res,
  input  logic              res_ready,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [DATA_W-1:0] wr_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [DATA_W-1:0] rd_data,
  output logic [OW-1:0]     occupancy
);

  localparam int SW = OW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] pos);
    logic [SW-1:0] r;
    r = (pos >= DEPTH_S) ? pos - DEPTH_S : pos;
    return r[AW-1:0];
  endfunction

  state_t        state, state_next;
  logic [AW-1:0] front, front_next;
  logic [OW-1:0] occ, occ_next;
  logic [OW-1:0] cnt, cnt_next;
  logic          emit_last, emit_last_next;

  op_t           op;
  logic          accept;
  logic          is_empty;
  logic          is_full;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] back_pos;
  logic [AW-1:0] tail_pos;
  logic [AW-1:0] show_pos;

  assign op        = op_t'(req.operation);
  assign accept    = req.valid && req.ready;
  assign is_empty  = (occ == '0);
  assign is_full   = (occ == DEPTH_O);
  assign front_dec = (front == '0) ? LAST_POS : front - 1'b1;
  assign front_inc = ring_wrap(SW'(front) + SW'(1));
  assign back_pos  = ring_wrap(SW'(front) + SW'(occ));
  assign tail_pos  = ring_wrap(SW'(front) + SW'(occ) - SW'(1));
  assign show_pos  = ring_wrap(SW'(front) + SW'(cnt));
  assign occupancy = occ;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !is_empty &&
            (op == OP_POP_FRONT || op == OP_POP_BACK || op == OP_SHOW)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (res_ready && emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    req.ready      = 1'b0;
    res_valid      = 1'b0;
    res            = '{data: '0, status: ST_OK, last: 1'b1};
    wr_en          = 1'b0;
    wr_addr        = back_pos;
    wr_data        = req.value;
    rd_en          = 1'b0;
    rd_addr        = show_pos;
    front_next     = front;
    occ_next       = occ;
    cnt_next       = cnt;
    emit_last_next = emit_last;
    case (state)
      S_IDLE: begin
        req.ready = res_ready;
        case (op)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            res_valid = req.valid;
            if (is_full) begin
              res.status = ST_FULL;
            end else if (accept) begin
              wr_en    = 1'b1;
              occ_next = occ + 1'b1;
              if (op == OP_PUSH_FRONT) begin
                wr_addr    = front_dec;
                front_next = front_dec;
              end
            end
          end
          OP_POP_FRONT, OP_POP_BACK, OP_SHOW: begin
            if (is_empty) begin
              res_valid  = req.valid;
              res.status = ST_EMPTY;
            end else if (accept) begin
              rd_en          = 1'b1;
              emit_last_next = 1'b1;
              if (op == OP_POP_FRONT) begin
                rd_addr    = front;
                front_next = front_inc;
                occ_next   = occ - 1'b1;
              end else if (op == OP_POP_BACK) begin
                rd_addr  = tail_pos;
                occ_next = occ - 1'b1;
              end else begin
                rd_addr        = front;
                cnt_next       = OW'(1);
                emit_last_next = (occ == OW'(1));
              end
            end
          end
          default: begin
            // undefined codes are taken and dropped
          end
        endcase
      end
      S_EMIT: begin
        res_valid = 1'b1;
        res.data  = rd_data;
        res.last  = emit_last;
        if (res_ready && !emit_last) begin
          rd_en          = 1'b1;
          cnt_next       = cnt + 1'b1;
          emit_last_next = (cnt + 1'b1 == occ);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      occ   <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      occ   <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    emit_last <= emit_last_next;
  end

endmodule

>>> design/deq_out_buf.sv
// output register stage between the sequencer and the result channel
// depends on deq_pkg and deq_out_if
module deq_out_buf import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     res_valid,
  input  result_t  res,
  output logic     res_ready,
  deq_out_if.source rsp
);

  result_t held;
  logic    valid;

  assign res_ready  = !valid || rsp.ready;
  assign rsp.valid  = valid;
  assign rsp.data   = held.data;
  assign rsp.status = held.status;
  assign rsp.last   = held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

endmodule

>>> design/double_ended_queue_unit.sv
// Double-ended queue of DEPTH signed 32-bit values kept in a ring inside one
// synchronous memory with one write port and one read port. Each request
// transaction carries an operation (push front, push back, pop front, pop back,
// show) and a value; undefined operation codes are taken and produce nothing.
// Pushes and every pop or show on an empty queue, as well as a push to a full
// queue, give one result transaction each. A pop first reads the memory and
// then hands over the read data. A show of N entries gives N results, front to
// back, the last one marked; the single memory read port sets a pace of one
// entry per cycle while the result channel takes them, and a stall holds it.
// Results pass through an output register, so each result is registered
// before it appears on the result channel. A new request is taken only
// while that register is empty or is being read in the same cycle, so a
// stalled result channel also holds off the request side. Reset clears
// pointers and occupancy at once; no clearing pass runs over the memory.
// Depends on deq_pkg, deq_in_if, deq_out_if, deq_mem, deq_ctrl, deq_out_buf
// and the assertion macros in double_ended_queue_unit_defines.svh.
`include "double_ended_queue_unit_defines.svh"

module double_ended_queue_unit import deq_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  deq_in_if.sink    req,
  deq_out_if.source rsp
);

  // ring address and occupancy widths
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);

  // sequencer to output register
  logic    res_valid;
  result_t res;
  logic    res_ready;

  // sequencer to memory
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic [OW-1:0] occupancy;

  // pointer bookkeeping and the read/modify sequence; memory writes happen only
  // on an accepted push in idle and reads only on pop/show, so the two never
  // meet on the same entry and no forwarding is needed
  deq_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .OW   (OW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .occupancy(occupancy)
  );

  // entry store, registered read data
  deq_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // result register toward the consumer
  deq_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready),
    .rsp      (rsp)
  );

  // ring never holds more than DEPTH entries
  `DEQ_ASSERT_NOW(a_occ_bound, 1'b1, occupancy <= OW'(DEPTH), "occupancy above depth")
  // a memory write only comes from an accepted push transaction
  `DEQ_ASSERT_NOW(a_wr_on_accept, wr_en, req.valid && req.ready, "write without request")
  // reads and writes never share a cycle
  `DEQ_ASSERT_NOW(a_no_rw_overlap, rd_en, !wr_en, "read and write in one cycle")
  // while read data is in flight no new request is taken
  `DEQ_ASSERT_NEXT(a_read_interlock, rd_en, !req.ready, "request taken during read")

endmodule
